>>> rtl/ffhbs_pkg.sv
// Shared types and constants for the FLAC frame header block-size decoder.
package ffhbs_pkg;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_SYNC1 = 4'd1,
    PH_SYNC2 = 4'd2,
    PH_CODE  = 4'd3,
    PH_CHAN  = 4'd4,
    PH_LEAD  = 4'd5,
    PH_SKIP  = 4'd6,
    PH_EXPL  = 4'd7,
    PH_CRC   = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SYNC  = 2'd1,
    ST_TRUNC = 2'd2,
    ST_LEAD  = 2'd3
  } status_t;

  localparam logic [0:0] REG_MIN_BLOCK = 1'b0;
  localparam logic [0:0] REG_MAX_BLOCK = 1'b1;

  localparam logic [7:0]  SYNC_HI      = 8'hFF;
  localparam logic [7:0]  SYNC_LO_MASK = 8'hFC;
  localparam logic [7:0]  SYNC_LO      = 8'hF8;
  localparam logic [7:0]  LEAD_SEVEN   = 8'hFE;
  localparam logic [15:0] MIN_RESET    = 16'd4096;
  localparam logic [15:0] MAX_RESET    = 16'd4096;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  block_code;
    logic [2:0]  skip_rem;
    logic [1:0]  expl_rem;
    logic [16:0] acc;
  } parse_state_t;

  typedef struct packed {
    logic        emit;
    logic [16:0] count;
    status_t     status;
  } parse_result_t;

endpackage

>>> rtl/ffhbs_step.sv
// Next-state and result logic for one header byte.
module ffhbs_step (
  input  ffhbs_pkg::parse_state_t  cur,
  input  logic [7:0]               data_byte,
  input  logic                     first_byte,
  input  logic                     last_byte,
  input  logic [15:0]              min_block,
  input  logic [15:0]              max_block,
  output ffhbs_pkg::parse_state_t  nxt,
  output ffhbs_pkg::parse_result_t res
);
  import ffhbs_pkg::*;

  parse_state_t  base;
  parse_state_t  work;
  parse_state_t  idle_st;
  logic          done;
  logic          bad;
  status_t       bad_code;
  logic          lead_ok;
  logic [2:0]    lead_num;
  logic [16:0]    shifted;
  logic [16:0]   code_cnt;

  // sample count from the block-size code
  always_comb begin
    unique case (data_byte[7:4])
      4'd0:    code_cnt = {1'b0, min_block};
      4'd1:    code_cnt = 17'd192;
      4'd2:    code_cnt = 17'd576;
      4'd3:    code_cnt = 17'd1152;
      4'd4:    code_cnt = 17'd2304;
      4'd5:    code_cnt = 17'd4608;
      4'd6,
      4'd7:    code_cnt = '0;
      default: code_cnt = 17'd256 << data_byte[6:4];
    endcase
  end

  // coded-number lead byte, exact prefix masks
  always_comb begin
    lead_ok  = 1'b1;
    lead_num = 3'd0;
    if (data_byte[7] == 1'b0) begin
      lead_num = 3'd0;
    end else if (data_byte[7:5] == 3'b110) begin
      lead_num = 3'd1;
    end else if (data_byte[7:4] == 4'b1110) begin
      lead_num = 3'd2;
    end else if (data_byte[7:3] == 5'b11110) begin
      lead_num = 3'd3;
    end else if (data_byte[7:2] == 6'b111110) begin
      lead_num = 3'd4;
    end else if (data_byte[7:1] == 7'b1111110) begin
      lead_num = 3'd5;
    end else if (data_byte == LEAD_SEVEN && min_block != max_block) begin
      lead_num = 3'd6;
    end else begin
      lead_ok = 1'b0;
    end
  end

  assign shifted = {cur.acc[8:0], data_byte};

  always_comb begin
    idle_st  = '{phase: PH_IDLE, block_code: 4'd0, skip_rem: 3'd0,
                 expl_rem: 2'd0, acc: 17'd0};
    base     = cur;
    if (first_byte) begin
      base       = idle_st;
      base.phase = PH_SYNC1;
    end
    work     = base;
    done     = 1'b0;
    bad      = 1'b0;
    bad_code = ST_SYNC;
    unique case (base.phase)
      PH_IDLE: ;
      PH_SYNC1: begin
        if (data_byte != SYNC_HI) bad = 1'b1;
        else work.phase = PH_SYNC2;
      end
      PH_SYNC2: begin
        if ((data_byte & SYNC_LO_MASK) != SYNC_LO) bad = 1'b1;
        else work.phase = PH_CODE;
      end
      PH_CODE: begin
        work.block_code = data_byte[7:4];
        work.acc        = code_cnt;
        work.phase      = PH_CHAN;
      end
      PH_CHAN: work.phase = PH_LEAD;
      PH_LEAD: begin
        if (!lead_ok) begin
          bad      = 1'b1;
          bad_code = ST_LEAD;
        end else if (lead_num != 3'd0) begin
          work.skip_rem = lead_num;
          work.phase    = PH_SKIP;
        end else if (base.block_code[3:1] == 3'b011) begin
          work.expl_rem = {base.block_code[0], ~base.block_code[0]};
          work.acc      = '0;
          work.phase    = PH_EXPL;
        end else begin
          work.phase = PH_CRC;
        end
      end
      PH_SKIP: begin
        work.skip_rem = base.skip_rem - 3'd1;
        if (work.skip_rem == 3'd0) begin
          if (base.block_code[3:1] == 3'b011) begin
            work.expl_rem = {base.block_code[0], ~base.block_code[0]};
            work.acc      = '0;
            work.phase    = PH_EXPL;
          end else begin
            work.phase = PH_CRC;
          end
        end
      end
      PH_EXPL: begin
        work.acc      = shifted;
        work.expl_rem = base.expl_rem - 2'd1;
        if (work.expl_rem == 2'd0) begin
          work.acc   = shifted + 17'd1;
          work.phase = PH_CRC;
        end
      end
      PH_CRC: done = 1'b1;
      default: work = idle_st;
    endcase

    nxt = work;
    res = '{emit: 1'b0, count: 17'd0, status: ST_OK};
    if (done) begin
      res = '{emit: 1'b1, count: base.acc, status: ST_OK};
      nxt = idle_st;
    end else if (bad) begin
      res = '{emit: 1'b1, count: 17'd0, status: bad_code};
      nxt = idle_st;
    end else if (last_byte && base.phase != PH_IDLE &&
                 base.phase <= PH_CRC) begin
      res = '{emit: 1'b1, count: 17'd0, status: ST_TRUNC};
      nxt = idle_st;
    end
  end

endmodule

>>> rtl/flac_frame_header_block_size.sv
// Top level of the FLAC frame header block-size decoder.
// Header bytes enter one per beat on in_*, in stream order; in_tuser marks the first
// byte of a frame header (it restarts parsing, dropping any frame in progress) and
// in_tlast marks the last byte available. Each byte is held in an input register,
// run through the parse step logic, and any result lands in an output register, so
// a new byte is taken every cycle while the result side keeps up. At most one
// result beat comes per frame: out_tdata carries the sample count (zero on error)
// and out_tuser the status: ok, bad sync, truncated header, or invalid coded-number
// lead byte. The CRC byte is skipped unchecked. The min/max block sizes are written
// over cfg_* (index 0 min, 1 max, other indexes ignored); the user must do so only
// while the block is idle, as the block itself does not enforce it.
module flac_frame_header_block_size (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] first_byte
  input  logic        in_tlast,   // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] sample_count, [23:17] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ffhbs_pkg::*;

  // registers
  logic          s0_valid_r;
  logic [7:0]    s0_byte_r;
  logic          s0_first_r;
  logic          s0_last_r;
  parse_state_t  st_r;
  parse_state_t  st_nxt;
  parse_result_t res;
  logic          out_valid_r;
  logic [16:0]   out_count_r;
  status_t       out_status_r;
  logic [15:0]   min_block_r;
  logic [15:0]   max_block_r;
  logic          advance;

  // stage byte moves on when the result slot is free or being drained
  assign advance   = s0_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s0_valid_r || advance;
  assign cfg_ready = 1'b1;

  ffhbs_step u_step (
    .cur        (st_r),
    .data_byte  (s0_byte_r),
    .first_byte (s0_first_r),
    .last_byte  (s0_last_r),
    .min_block  (min_block_r),
    .max_block  (max_block_r),
    .nxt        (st_nxt),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{phase: PH_IDLE, block_code: 4'd0, skip_rem: 3'd0,
                       expl_rem: 2'd0, acc: 17'd0};
      min_block_r <= MIN_RESET;
      max_block_r <= MAX_RESET;
    end else begin
      if (in_tready) begin
        s0_valid_r <= in_tvalid;
      end
      if (advance) begin
        st_r        <= st_nxt;
        out_valid_r <= res.emit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_index[1] == 1'b0) begin
        if (cfg_index[0] == REG_MIN_BLOCK) min_block_r <= cfg_data;
        if (cfg_index[0] == REG_MAX_BLOCK) max_block_r <= cfg_data;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_byte_r  <= in_tdata;
      s0_first_r <= in_tuser;
      s0_last_r  <= in_tlast;
    end
    if (advance && res.emit) begin
      out_count_r  <= res.count;
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_count_r};
  assign out_tuser  = out_status_r;

  a_err_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_count_r == 17'd0)
    else $error("error result with nonzero sample count");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.emit |=> st_r.phase == PH_IDLE)
    else $error("parser not idle after a result");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_SKIP |-> st_r.skip_rem != 3'd0)
    else $error("skip phase with empty skip count");

  a_expl_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_EXPL |-> st_r.expl_rem != 2'd0)
    else $error("explicit size phase with empty byte count");

endmodule

>>> dv/tb.sv
// Testbench for the FLAC frame header block-size decoder: directed table, random frames, scoreboard.
`timescale 1ns / 1ps

module tb;
  import ffhbs_pkg::*;

  // Index that decodes to no register; writes to it must be dropped.
  localparam logic [1:0] REG_SPARE = 2'd2;
  localparam int PHASE_ITEMS = 120;

  // One header byte to send. When 'typed' is set the expected outcome is the one
  // written in the row (has_result/count/status); otherwise the decoder model decides.
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic        typed;
    logic        has_result;
    logic [16:0] count;
    status_t     status;
  } header_row_t;

  typedef struct packed {
    logic [16:0] count;
    status_t     status;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] data_byte
  logic        in_tuser = 1'b0; // [0] first_byte
  logic        in_tlast = 1'b0; // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [16:0] sample_count, [23:17] zero
  logic [1:0]  out_tuser;       // [1:0] status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  flac_frame_header_block_size DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed table, run with the reset block sizes (4096/4096).
  header_row_t directed_rows [23] = '{
    // byte outside any frame: ignored
    '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 17'd0, ST_OK},
    // bad first sync byte, also tagged last: sync error wins over truncation
    '{8'h7F, 1'b1, 1'b1, 1'b1, 1'b1, 17'd0, ST_SYNC},
    // bad second sync byte
    '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, ST_OK},
    '{8'hF4, 1'b0, 1'b0, 1'b1, 1'b1, 17'd0, ST_SYNC},
    // lead byte 0xFF, tagged last: lead error wins over truncation
    '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, ST_OK},
    '{8'hF9, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0, ST_OK},
    '{8'hC0, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0, ST_OK},
    '{8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 17'd0, ST_LEAD},
    // frame cut short by a new start mark, then 16-bit explicit size 0xFFFF + 1
    '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, ST_OK},
    '{8'hF8, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0, ST_OK},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, ST_OK},
    '{8'hF8, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0, ST_OK},
    '{8'h70, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0, ST_OK},
    '{8'hC3, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0, ST_OK},
    '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0, ST_OK},
    '{8'h5A, 1'b0, 1'b0, 1'b1, 1'b1, 17'd65536, ST_OK},
    // header ends on the block-code byte: truncated
    '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, ST_OK},
    '{8'hF8, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0, ST_OK},
    '{8'hF0, 1'b0, 1'b1, 1'b1, 1'b1, 17'd0, ST_TRUNC}
  };

  // ---------------------------------------------------------------------------
  // Header decoder model: its own copy of the parse state and block sizes.
  // ---------------------------------------------------------------------------
  phase_t      hdr_phase = PH_IDLE;
  logic [3:0]  hdr_code = '0;
  logic [2:0]  hdr_skip = '0;
  logic [1:0]  hdr_expl = '0;
  logic [16:0] hdr_acc = '0;
  logic [15:0] cur_min_bs = MIN_RESET;
  logic [15:0] cur_max_bs = MAX_RESET;

  frame_result_t frame_results_due [$];
  int            items_sent = 0;
  int            mismatches = 0;
  logic          sender_burst = 1'b0;
  logic          hold_off = 1'b0;

  function automatic void clear_parse();
    hdr_phase = PH_IDLE;
    hdr_code  = '0;
    hdr_skip  = '0;
    hdr_expl  = '0;
    hdr_acc   = '0;
  endfunction

  // After the coded number: explicit size bytes for codes 6/7, else straight to CRC.
  function automatic void enter_tail();
    if (hdr_code == 4'd6 || hdr_code == 4'd7) begin
      hdr_expl  = 2'(hdr_code - 4'd5);
      hdr_acc   = '0;
      hdr_phase = PH_EXPL;
    end else begin
      hdr_phase = PH_CRC;
    end
  endfunction

  function automatic void decode_header_byte(input logic [7:0] b, input logic first,
                                             input logic last, output logic got,
                                             output logic [16:0] count, output status_t st);
    int unsigned run_len;
    got   = 1'b0;
    count = '0;
    st    = ST_OK;
    run_len = 0;
    if (first) begin
      clear_parse();
      hdr_phase = PH_SYNC1;
    end
    if (hdr_phase == PH_IDLE) return;
    case (hdr_phase)
      PH_SYNC1: begin
        if (b != SYNC_HI) begin
          got = 1'b1; st = ST_SYNC; clear_parse(); return;
        end
        hdr_phase = PH_SYNC2;
      end
      PH_SYNC2: begin
        if ((b & SYNC_LO_MASK) != SYNC_LO) begin
          got = 1'b1; st = ST_SYNC; clear_parse(); return;
        end
        hdr_phase = PH_CODE;
      end
      PH_CODE: begin
        hdr_code = b[7:4];
        if (hdr_code == 4'd0)      hdr_acc = {1'b0, cur_min_bs};
        else if (hdr_code == 4'd1) hdr_acc = 17'd192;
        else if (hdr_code <= 4'd5) hdr_acc = 17'd576 << (hdr_code - 4'd2);
        else if (hdr_code >= 4'd8) hdr_acc = 17'd256 << (hdr_code - 4'd8);
        else                       hdr_acc = '0;
        hdr_phase = PH_CHAN;
      end
      PH_CHAN: hdr_phase = PH_LEAD;
      PH_LEAD: begin
        // exact prefix masks: continuation bytes and 0xFF never qualify
        if (!b[7])                       run_len = 0;
        else if ((b & 8'hE0) == 8'hC0)   run_len = 1;
        else if ((b & 8'hF0) == 8'hE0)   run_len = 2;
        else if ((b & 8'hF8) == 8'hF0)   run_len = 3;
        else if ((b & 8'hFC) == 8'hF8)   run_len = 4;
        else if ((b & 8'hFE) == 8'hFC)   run_len = 5;
        else if (b == LEAD_SEVEN && cur_min_bs != cur_max_bs) run_len = 6;
        else begin
          got = 1'b1; st = ST_LEAD; clear_parse(); return;
        end
        if (run_len != 0) begin
          hdr_skip  = 3'(run_len);
          hdr_phase = PH_SKIP;
        end else begin
          enter_tail();
        end
      end
      PH_SKIP: begin
        hdr_skip = hdr_skip - 3'd1;
        if (hdr_skip == 3'd0) enter_tail();
      end
      PH_EXPL: begin
        hdr_acc  = {hdr_acc[8:0], b};
        hdr_expl = hdr_expl - 2'd1;
        if (hdr_expl == 2'd0) begin
          hdr_acc   = hdr_acc + 17'd1;
          hdr_phase = PH_CRC;
        end
      end
      PH_CRC: begin
        // CRC byte is not checked; completing the header beats last_byte
        got = 1'b1; count = hdr_acc; st = ST_OK; clear_parse(); return;
      end
      default: begin
        clear_parse(); return;
      end
    endcase
    if (last) begin
      got = 1'b1; st = ST_TRUNC; clear_parse();
    end
  endfunction

  // Gap lengths: mostly short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic header_row_t loose_row(input logic [7:0] b, input logic first,
                                            input logic last);
    return '{b, first, last, 1'b0, 1'b0, 17'd0, ST_OK};
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t ERROR %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising edge; returns at the edge the beat was taken,
  // leaving in_tvalid high unless a gap follows.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input header_row_t row);
    logic          got;
    logic [16:0]   cnt;
    status_t       st;
    in_tvalid <= 1'b1;
    in_tdata  <= row.data;
    in_tuser  <= row.first;
    in_tlast  <= row.last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    decode_header_byte(row.data, row.first, row.last, got, cnt, st);
    if (row.typed) begin
      got = row.has_result;
      cnt = row.count;
      st  = row.status;
    end
    if (got) frame_results_due.push_back('{count: cnt, status: st});
    if (!sender_burst && $urandom_range(0, 1) == 1) begin
      in_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write of a batch.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == 2'(REG_MIN_BLOCK))      cur_min_bs = value;
    else if (idx == 2'(REG_MAX_BLOCK)) cur_max_bs = value;
  endtask

  // Quiesce: no beat offered, every result in, then wait out the bytes still in the
  // input and output registers that never produce a result.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] lead_for_run(input int run_len);
    logic [7:0] r;
    r = 8'($urandom);
    case (run_len)
      0:       return {1'b0, r[6:0]};
      1:       return {3'b110, r[4:0]};
      2:       return {4'b1110, r[3:0]};
      3:       return {5'b11110, r[2:0]};
      4:       return {6'b111110, r[1:0]};
      5:       return {7'b1111110, r[0]};
      default: return LEAD_SEVEN;
    endcase
  endfunction

  // One random frame: mostly well-formed headers with random content, some broken
  // (bad sync, cut short, early last mark), some loose noise bytes.
  task automatic send_random_frame();
    logic [7:0] hdr [$];
    int         kind, code, run_len, sel, cut, last_pos, i;
    kind = $urandom_range(0, 99);
    sender_burst = ($urandom_range(0, 3) == 0);
    if (kind < 12) begin
      repeat ($urandom_range(1, 6))
        send_beat(loose_row(8'($urandom), $urandom_range(0, 5) == 0,
                            $urandom_range(0, 7) == 0));
      return;
    end
    code = $urandom_range(0, 15);
    hdr.push_back(SYNC_HI);
    hdr.push_back({6'b111110, 2'($urandom)});
    hdr.push_back({4'(code), 4'($urandom)});
    hdr.push_back(8'($urandom));
    sel = $urandom_range(0, 19);
    if (sel < 2) begin
      // any lead byte at all, valid or not
      hdr.push_back(8'($urandom));
      run_len = $urandom_range(0, 6);
    end else if (sel == 2) begin
      hdr.push_back({2'b10, 6'($urandom)});
      run_len = 0;
    end else begin
      run_len = $urandom_range(0, 6);
      hdr.push_back(lead_for_run(run_len));
    end
    repeat (run_len) hdr.push_back({2'b10, 6'($urandom)});
    if (code == 6 || code == 7) hdr.push_back(8'($urandom));
    if (code == 7) hdr.push_back(8'($urandom));
    hdr.push_back(8'($urandom));

    last_pos = -1;
    if (kind < 18) begin
      hdr[$urandom_range(0, 1)] = 8'($urandom);
    end else if (kind < 26) begin
      // cut short without a last mark; the next start mark restarts the parser
      cut = $urandom_range(1, hdr.size() - 1);
      while (hdr.size() > cut) void'(hdr.pop_back());
    end else if (kind < 34) begin
      last_pos = $urandom_range(0, hdr.size() - 1);
    end else if (kind < 42) begin
      last_pos = hdr.size() - 1;
    end
    for (i = 0; i < hdr.size(); i++)
      send_beat(loose_row(hdr[i], i == 0, i == last_pos));
  endtask

  task automatic run_random(input int n_items);
    int start;
    start = items_sent;
    while (items_sent - start < n_items) send_random_frame();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold-off to back the block up.
  // ---------------------------------------------------------------------------
  initial begin
    int run_len;
    int gap;
    @(posedge clk);
    forever begin
      // occasional long stretch with the receiver ready unless held off
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      repeat (run_len) begin
        out_tready <= !hold_off;
        @(posedge clk);
      end
      gap = pick_gap();
      repeat (gap) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Long hold-off while the sender keeps offering bytes: in_tready must drop.
  initial begin
    wait (items_sent >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Scoreboard: each result beat against the oldest expected frame result.
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_results_due.size() == 0) begin
        flag_error($sformatf("result beat with none expected: tdata=%h tuser=%0d",
                             out_tdata, out_tuser));
      end else begin
        want = frame_results_due.pop_front();
        if (out_tdata !== {7'd0, want.count})
          flag_error($sformatf("sample count: expected %0d, got tdata=%h",
                               want.count, out_tdata));
        if (out_tuser !== want.status)
          flag_error($sformatf("status: expected %s, got %0d",
                               want.status.name(), out_tuser));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence: directed table, then random frames under several
  // block-size settings, extremes included.
  // ---------------------------------------------------------------------------
  initial begin
    int          ph;
    logic [15:0] new_min, new_max;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset block sizes first
    foreach (directed_rows[i]) send_beat(directed_rows[i]);
    run_random(PHASE_ITEMS);

    for (ph = 1; ph <= 6; ph++) begin
      wait_idle();
      case (ph)
        1: begin new_min = 16'd16;    new_max = 16'd65535; end
        2: begin new_min = 16'd65535; new_max = 16'd65535; end
        3: begin new_min = 16'd16;    new_max = 16'd16;    end
        4: begin new_min = 16'd65535; new_max = 16'd16;    end
        5: begin
          new_min = 16'($urandom_range(16, 65535));
          new_max = 16'($urandom_range(16, 65535));
        end
        default: begin
          new_min = 16'($urandom_range(16, 65535));
          new_max = new_min;
        end
      endcase
      write_reg(2'(REG_MIN_BLOCK), new_min);
      write_reg(2'(REG_MAX_BLOCK), new_max);
      // stray write to an unmapped index must not disturb either size
      if (ph == 3) write_reg(REG_SPARE, 16'($urandom));
      cfg_valid <= 1'b0;
      run_random(PHASE_ITEMS);
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
